// ===== hw/rtl/sector_cache_clock_replacement_macros.svh =====
// Assertion helpers for the sector cache controller.
// Each macro expects clk and rst_n in scope.
`ifndef SECTOR_CACHE_CLOCK_REPLACEMENT_MACROS_SVH
`define SECTOR_CACHE_CLOCK_REPLACEMENT_MACROS_SVH

// Same-cycle implication.
`define SCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define SCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    localparam int NUM_WAYS    = 64;
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SECTOR_W    = 32;
    localparam int OUT_WAY_W   = 6;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    typedef struct packed {
        logic req_load;
        logic idx_clr;
        logic idx_inc;
        logic rd_idx;
        logic rd_hand;
        logic lk_hit;
        logic vs_step;
        logic vs_fill;
        logic fl_emit;
    } scc_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       lk_match;
        logic       idx_last;
        logic       vd_idx;
        logic       victim_ok;
        logic       out_pend;
        logic       out_done;
        logic       out_last;
    } scc_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sector_cache_clock_replacement.sv =====
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement
// Tag and control engine of a fully associative sector cache, clock policy.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with func (read, write, flush) and
//   sector. Results leave on out_valid/out_ready with way, hit, fetch,
//   write_back, write_back_sector and last. One request is in flight at once;
//   in_ready is high only while the engine is idle.
//   A lookup reads the tag memory one way at a time, with a read and a
//   compare state per way, until a hit or the last way. A miss then steps
//   the clock hand (up to NUM_WAYS+1 steps) to a victim, reads its tag and
//   fills it. A flush tests each way; a dirty way also takes a read and an
//   emit state, plus the wait for each result to be taken. Func 3 is taken
//   and dropped.
//   Reset clears all valid, dirty and referenced bits and parks the hand on
//   the last way, so the first miss fills way 0. The tag memory is not
//   cleared; entries are only used while valid.
//   When the receiver stalls, the result is held in the output register and
//   the engine waits; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_clock_replacement (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    func,
    input  wire logic [scc_pkg::SECTOR_W-1:0]  sector,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [scc_pkg::OUT_WAY_W-1:0]      way,
    output logic                               hit,
    output logic                               fetch,
    output logic                               write_back,
    output logic [scc_pkg::SECTOR_W-1:0]       write_back_sector,
    output logic                               last
);
    import scc_pkg::*;

    scc_cmd_t  cmd;
    scc_stat_t stat;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    scc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .func              (func),
        .sector            (sector),
        .cmd               (cmd),
        .stat              (stat),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .way               (way),
        .hit               (hit),
        .fetch             (fetch),
        .write_back        (write_back),
        .write_back_sector (write_back_sector),
        .last              (last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/scc_dp.sv =====
// ----------------------------------------------------------------------------
// scc_dp
// Tag memory, per-way flags, clock hand, scan counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [1:0]                    func,
    input  wire logic [scc_pkg::SECTOR_W-1:0]  sector,
    input  wire scc_pkg::scc_cmd_t             cmd,
    output scc_pkg::scc_stat_t                 stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [scc_pkg::OUT_WAY_W-1:0]      way,
    output logic                               hit,
    output logic                               fetch,
    output logic                               write_back,
    output logic [scc_pkg::SECTOR_W-1:0]       write_back_sector,
    output logic                               last
);
    import scc_pkg::*;

    logic [SECTOR_W-1:0] tag_mem [NUM_WAYS];
    logic [SECTOR_W-1:0] rdata_reg;

    logic [NUM_WAYS-1:0] valid_reg, valid_next;
    logic [NUM_WAYS-1:0] dirty_reg, dirty_next;
    logic [NUM_WAYS-1:0] ref_reg, ref_next;
    logic [WAY_W-1:0]    hand_reg, hand_next;
    logic [WAY_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]          func_reg;
    logic [SECTOR_W-1:0] sector_reg;

    logic                out_valid_reg, out_valid_next;
    logic [OUT_WAY_W-1:0] way_reg;
    logic                hit_reg, fetch_reg, wb_reg, last_reg;
    logic [SECTOR_W-1:0] wbs_reg;

    logic [WAY_W-1:0]    hand_inc;
    logic [NUM_WAYS-1:0] vd_vec;
    logic                more_dirty;
    logic                fl_last;
    logic                vict_wb;

    assign hand_inc   = (hand_reg == WAY_W'(NUM_WAYS - 1)) ? '0 : hand_reg + 1'b1;
    assign vd_vec     = valid_reg & dirty_reg;
    assign more_dirty = |((vd_vec >> idx_reg) >> 1);
    assign fl_last    = (cnt_reg == CNT_W'(MAX_RESULTS - 1)) || !more_dirty;
    assign vict_wb    = valid_reg[hand_reg] && dirty_reg[hand_reg];

    // Tag memory: one write at the hand, one registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.vs_fill)
        begin
            tag_mem[hand_reg] <= sector_reg;
        end
        if (cmd.rd_idx)
        begin
            rdata_reg <= tag_mem[idx_reg];
        end
        else if (cmd.rd_hand)
        begin
            rdata_reg <= tag_mem[hand_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            func_reg   <= func;
            sector_reg <= sector;
        end
        if (cmd.lk_hit)
        begin
            way_reg   <= OUT_WAY_W'(idx_reg);
            hit_reg   <= 1'b1;
            fetch_reg <= 1'b0;
            wb_reg    <= 1'b0;
            wbs_reg   <= '0;
            last_reg  <= 1'b1;
        end
        else if (cmd.vs_fill)
        begin
            way_reg   <= OUT_WAY_W'(hand_reg);
            hit_reg   <= 1'b0;
            fetch_reg <= 1'b1;
            wb_reg    <= vict_wb;
            wbs_reg   <= vict_wb ? rdata_reg : '0;
            last_reg  <= 1'b1;
        end
        else if (cmd.fl_emit)
        begin
            way_reg   <= OUT_WAY_W'(idx_reg);
            hit_reg   <= 1'b0;
            fetch_reg <= 1'b0;
            wb_reg    <= 1'b1;
            wbs_reg   <= rdata_reg;
            last_reg  <= fl_last;
        end
    end

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        ref_next       = ref_reg;
        hand_next      = hand_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.req_load)
        begin
            cnt_next = '0;
        end
        if (cmd.lk_hit)
        begin
            ref_next[idx_reg] = 1'b1;
            if (func_reg == FUNC_WRITE)
            begin
                dirty_next[idx_reg] = 1'b1;
            end
        end
        if (cmd.vs_step)
        begin
            hand_next = hand_inc;
            // Second chance: drop the referenced bit and keep going.
            if (valid_reg[hand_inc] && ref_reg[hand_inc])
            begin
                ref_next[hand_inc] = 1'b0;
            end
        end
        if (cmd.vs_fill)
        begin
            valid_next[hand_reg] = 1'b1;
            ref_next[hand_reg]   = 1'b1;
            dirty_next[hand_reg] = (func_reg == FUNC_WRITE);
        end
        if (cmd.fl_emit)
        begin
            dirty_next[idx_reg] = 1'b0;
            cnt_next            = cnt_reg + 1'b1;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.lk_hit || cmd.vs_fill || cmd.fl_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            ref_reg       <= '0;
            hand_reg      <= WAY_W'(NUM_WAYS - 1);
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            ref_reg       <= ref_next;
            hand_reg      <= hand_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.func      = func_reg;
    assign stat.lk_match  = valid_reg[idx_reg] && (rdata_reg == sector_reg);
    assign stat.idx_last  = (idx_reg == WAY_W'(NUM_WAYS - 1));
    assign stat.vd_idx    = vd_vec[idx_reg];
    assign stat.victim_ok = !valid_reg[hand_inc] || !ref_reg[hand_inc];
    assign stat.out_pend  = out_valid_reg;
    assign stat.out_done  = out_valid_reg && out_ready;
    assign stat.out_last  = last_reg;

    assign out_valid         = out_valid_reg;
    assign way               = way_reg;
    assign hit               = hit_reg;
    assign fetch             = fetch_reg;
    assign write_back        = wb_reg;
    assign write_back_sector = wbs_reg;
    assign last              = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Request sequencer: lookup scan, clock victim search and flush scan.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sector_cache_clock_replacement_macros.svh"

module scc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          func,
    input  wire scc_pkg::scc_stat_t  stat,
    output scc_pkg::scc_cmd_t        cmd
);
    import scc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LK_RD   = 4'd1;
    localparam logic [3:0] S_LK_CMP  = 4'd2;
    localparam logic [3:0] S_VS_STEP = 4'd3;
    localparam logic [3:0] S_VS_RD   = 4'd4;
    localparam logic [3:0] S_VS_WR   = 4'd5;
    localparam logic [3:0] S_FL_TEST = 4'd6;
    localparam logic [3:0] S_FL_RD   = 4'd7;
    localparam logic [3:0] S_FL_EMIT = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.req_load = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    priority if (func == FUNC_FLUSH)
                    begin
                        state_next = S_FL_TEST;
                    end
                    else if (func == FUNC_READ || func == FUNC_WRITE)
                    begin
                        state_next = S_LK_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LK_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                priority if (stat.lk_match)
                begin
                    cmd.lk_hit = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_VS_STEP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_VS_STEP:
            begin
                cmd.vs_step = 1'b1;
                if (stat.victim_ok)
                begin
                    state_next = S_VS_RD;
                end
            end
            S_VS_RD:
            begin
                cmd.rd_hand = 1'b1;
                state_next  = S_VS_WR;
            end
            S_VS_WR:
            begin
                cmd.vs_fill = 1'b1;
                state_next  = S_OUT;
            end
            S_FL_TEST:
            begin
                priority if (stat.vd_idx)
                begin
                    state_next = S_FL_RD;
                end
                else if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_FL_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_FL_EMIT;
            end
            S_FL_EMIT:
            begin
                cmd.fl_emit = 1'b1;
                cmd.idx_inc = !stat.idx_last;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_done)
                begin
                    // Resume the flush scan unless this was its final write-back.
                    if (stat.func == FUNC_FLUSH && !stat.out_last)
                    begin
                        state_next = S_FL_TEST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SCC_ASSERT_NOW(a_out_pending, state_reg == S_OUT, stat.out_pend)
    `SCC_ASSERT_NOW(a_idle_no_result, state_reg == S_IDLE, !stat.out_pend)
    `SCC_ASSERT_NEXT(a_hit_to_out, (state_reg == S_LK_CMP) && stat.lk_match, state_reg == S_OUT)
    `SCC_ASSERT_NEXT(a_victim_read, (state_reg == S_VS_STEP) && stat.victim_ok,
                     state_reg == S_VS_RD)

endmodule

`default_nettype wire

// ===== tb/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// Watches the request and result channels of the sector cache engine, keeps
// its own copy of tags, valid, dirty and referenced bits and the clock hand,
// and compares every result with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_checker
    import scc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [1:0]           func,
    input  wire logic [SECTOR_W-1:0]  sector,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic [OUT_WAY_W-1:0] way,
    input  wire logic                 hit,
    input  wire logic                 fetch,
    input  wire logic                 write_back,
    input  wire logic [SECTOR_W-1:0]  write_back_sector,
    input  wire logic                 last,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [OUT_WAY_W-1:0] way;
        logic                 hit;
        logic                 fetch;
        logic                 write_back;
        logic [SECTOR_W-1:0]  wb_sector;
        logic                 last;
    } cache_result_t;

    cache_result_t          result_queue[$];
    logic [SECTOR_W-1:0]    tags[NUM_WAYS];
    logic [NUM_WAYS-1:0]    valid_q;
    logic [NUM_WAYS-1:0]    dirty_q;
    logic [NUM_WAYS-1:0]    ref_q;
    logic [WAY_W-1:0]       hand;

    assign pending = result_queue.size();

    task automatic predict_request(input logic [1:0] f, input logic [SECTOR_W-1:0] s);
        cache_result_t r;
        int            n;
        int            found;
        int            victim;
        begin
            if (f == FUNC_FLUSH) begin
                n = 0;
                for (int w = 0; w < NUM_WAYS && n < MAX_RESULTS; w++) begin
                    if (valid_q[w] && dirty_q[w]) begin
                        r = '{way: w[OUT_WAY_W-1:0], hit: 1'b0, fetch: 1'b0,
                              write_back: 1'b1, wb_sector: tags[w], last: 1'b0};
                        result_queue.push_back(r);
                        dirty_q[w] = 1'b0;
                        n++;
                    end
                end
                if (n > 0)
                    result_queue[$].last = 1'b1;
            end
            else if (f == FUNC_READ || f == FUNC_WRITE) begin
                found = -1;
                for (int w = NUM_WAYS - 1; w >= 0; w--)
                    if (valid_q[w] && tags[w] == s)
                        found = w;
                if (found >= 0) begin
                    ref_q[found] = 1'b1;
                    if (f == FUNC_WRITE)
                        dirty_q[found] = 1'b1;
                    r = '{way: found[OUT_WAY_W-1:0], hit: 1'b1, fetch: 1'b0,
                          write_back: 1'b0, wb_sector: '0, last: 1'b1};
                end
                else begin
                    victim = 0;
                    for (int k = 0; k < 2 * NUM_WAYS; k++) begin
                        hand   = hand + 1'b1;
                        victim = hand;
                        if (!valid_q[victim])
                            break;
                        if (ref_q[victim])
                            ref_q[victim] = 1'b0;
                        else
                            break;
                    end
                    r = '{way: victim[OUT_WAY_W-1:0], hit: 1'b0, fetch: 1'b1,
                          write_back: valid_q[victim] && dirty_q[victim],
                          wb_sector: (valid_q[victim] && dirty_q[victim]) ?
                                     tags[victim] : '0,
                          last: 1'b1};
                    tags[victim]    = s;
                    valid_q[victim] = 1'b1;
                    ref_q[victim]   = 1'b1;
                    dirty_q[victim] = (f == FUNC_WRITE);
                end
                result_queue.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_result_t e;
        cache_result_t got;
        if (!rst_n) begin
            result_queue.delete();
            valid_q    = '0;
            dirty_q    = '0;
            ref_q      = '0;
            hand       = WAY_W'(NUM_WAYS - 1);
            fail_count = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                got = '{way: way, hit: hit, fetch: fetch, write_back: write_back,
                        wb_sector: write_back_sector, last: last};
                if (result_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: %p", got);
                end
                else begin
                    e = result_queue.pop_front();
                    if (got !== e) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, actual %p", e, got);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_request(func, sector);
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives read, write and flush requests into the sector cache engine with
// random idling and a long result stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import scc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [SECTOR_W-1:0]  sector;
    logic                 out_valid;
    logic                 out_ready;
    logic [OUT_WAY_W-1:0] way;
    logic                 hit;
    logic                 fetch;
    logic                 write_back;
    logic [SECTOR_W-1:0]  write_back_sector;
    logic                 last;
    int                   fail_count;
    int                   pending;
    bit                   calm;
    bit                   hold_off;
    bit                   stim_done;
    int                   quiet_cycles;
    logic [SECTOR_W-1:0]  working_set[16];

    sector_cache_clock_replacement i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .sector(sector), .out_valid(out_valid), .out_ready(out_ready),
        .way(way), .hit(hit), .fetch(fetch), .write_back(write_back),
        .write_back_sector(write_back_sector), .last(last)
    );

    scc_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .sector(sector), .out_valid(out_valid), .out_ready(out_ready),
        .way(way), .hit(hit), .fetch(fetch), .write_back(write_back),
        .write_back_sector(write_back_sector), .last(last),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input logic [1:0] f, input logic [SECTOR_W-1:0] s);
        begin
            while (!calm && $urandom_range(99) < 34) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            func     <= f;
            sector   <= s;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    // Result side: random stalls, plus a long hold-off while requests keep coming.
    always @(posedge clk)
    begin
        if (hold_off || (!calm && $urandom_range(99) < 34))
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        int pick;
        in_valid  = 1'b0;
        func      = FUNC_READ;
        sector    = '0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, hits, write-backs, flush with none dirty, ignored func.
        send_request(FUNC_FLUSH, '0);
        send_request(FUNC_READ, '0);
        send_request(FUNC_WRITE, 32'hFFFF_FFFF);
        send_request(FUNC_READ, 32'hFFFF_FFFF);
        send_request(FUNC_WRITE, 32'h0);
        send_request(FUNC_READ, 32'hAAAA_5555);
        send_request(FUNC_WRITE, 32'h5555_AAAA);
        send_request(2'd3, 32'h1234_5678);
        send_request(FUNC_FLUSH, 32'hFFFF_FFFF);
        send_request(FUNC_FLUSH, '0);
        // Fill every way dirty, then evict to force victim write-backs.
        for (int i = 0; i < NUM_WAYS + 4; i++)
            send_request(FUNC_WRITE, 32'h8000_0000 + i);
        send_request(FUNC_FLUSH, '0);

        for (int i = 0; i < 16; i++)
            working_set[i] = $urandom;

        for (int n = 0; n < 240; n++) begin
            calm = (n >= 120 && n < 180);
            if (n == 200) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            pick = $urandom_range(99);
            if (pick < 6)
                send_request(FUNC_FLUSH, $urandom);
            else if (pick < 8)
                send_request(2'd3, $urandom);
            else if (pick < 60)
                send_request(2'($urandom_range(1)), working_set[4'($urandom_range(15))]);
            else if (pick < 70)
                send_request(2'($urandom_range(1)), 32'h8000_0000 + $urandom_range(70));
            else
                send_request(2'($urandom_range(1)), $urandom);
        end
        in_valid <= 1'b0;
        calm      = 1'b0;
        stim_done = 1'b1;
    end

    // Watchdog and end of run.
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
            if (stim_done && pending == 0) begin
                repeat (300) @(posedge clk);
                if (fail_count == 0 && pending == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
